// ===== sv/mexp_pkg.sv =====
// Shared constants and types for the modular exponentiation block.
package mexp_pkg;

	// Width of every operand and result port
	localparam int FIELD_W = 64;

	// Default working width of the datapath
	localparam int OPERAND_WIDTH_DEF = 64;

	// Status of one serial modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

endpackage

// ===== sv/mexp_modmul.sv =====
// Bit-serial modular multiplier: interleaved double-and-add, MSB-first, add gated by the bit.
module mexp_modmul #(
	parameter int W = mexp_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        mcand,
	input  logic [W-1:0]        mplr,
	input  logic [W-1:0]        modulus,
	output logic [W-1:0]        product,
	output mexp_pkg::mm_stat_t  stat
);
	import mexp_pkg::*;

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  acc_q;
	logic [W-1:0]  mcand_q;
	logic [W-1:0]  mplr_q;
	logic [CW-1:0] cnt_q;
	logic          phase_q;
	logic          busy_q;
	logic          done_q;

	logic [W-1:0]  addend;
	logic [W:0]    sum;
	logic [W+1:0]  diff;
	logic [W-1:0]  acc_next;

	// (acc + addend) mod m, both terms already below m
	always_comb begin
		addend   = phase_q ? mcand_q : acc_q;
		sum      = {1'b0, acc_q} + {1'b0, addend};
		diff     = {1'b0, sum} - {2'b00, modulus};
		acc_next = diff[W+1] ? sum[W-1:0] : diff[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			mcand_q <= '0;
			mplr_q  <= '0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			// one-cycle pulse after the add of the last multiplier bit
			done_q <= !start && busy_q && phase_q && (cnt_q == '0);
			if (start) begin
				acc_q   <= '0;
				mcand_q <= mcand;
				mplr_q  <= mplr;
				cnt_q   <= CW'(W - 1);
				phase_q <= 1'b0;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				if (!phase_q) begin
					acc_q   <= acc_next;
					phase_q <= 1'b1;
				end else begin
					if (mplr_q[W-1]) begin
						acc_q <= acc_next;
					end
					mplr_q  <= mplr_q << 1;
					phase_q <= 1'b0;
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== sv/modular_exponentiation.sv =====
// Modular exponentiation: base ** exponent mod modulus, right-to-left square-and-multiply.
//
// Input channel (in_valid / in_ready) takes base_value, exponent_value and
// modulus_value in one transaction; the output channel (out_valid / out_ready)
// returns power_result and zero_modulus_error. One result per transaction.
// Only the low OPERAND_WIDTH bits of each operand are used.
// A zero modulus answers 0 with zero_modulus_error set, passing from
// acceptance to the finish state and out once the output register is free.
// Otherwise the base is first reduced by the modulus, then each exponent bit
// runs a square and a conditional multiply side by side on two bit-serial
// modular multipliers, each doing one doubling and one conditional add per
// multiplier bit. One transaction is worked on at a time. The result sits
// in an output register, so the next transaction is taken while a result
// waits; a stalled receiver holds only the finished result, and a further
// finished result waits inside until that register frees up.
// Reset is asynchronous and clears all state; no clearing pass is needed.
module modular_exponentiation #(
	parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mexp_pkg::FIELD_W-1:0] base_value,
	input  logic [mexp_pkg::FIELD_W-1:0] exponent_value,
	input  logic [mexp_pkg::FIELD_W-1:0] modulus_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mexp_pkg::FIELD_W-1:0] power_result,
	output logic                         zero_modulus_error
);
	import mexp_pkg::*;

	localparam int W = OPERAND_WIDTH;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REDUCE = 5'b00010,
		ST_LOOP   = 5'b00100,
		ST_MUL    = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t       state_q;
	logic [W-1:0] b_q;
	logic [W-1:0] e_q;
	logic [W-1:0] m_q;
	logic [W-1:0] r_q;
	logic [W-1:0] res_q;
	logic         err_q;
	logic [W-1:0] pow_q;
	logic         oerr_q;
	logic         out_valid_q;

	logic         in_acc;
	logic [W-1:0] in_m;
	logic [W-1:0] in_one;
	logic         a_start;
	logic         b_start;
	logic [W-1:0] a_mcand;
	logic [W-1:0] a_mplr;
	logic [W-1:0] a_prod;
	logic [W-1:0] b_prod;
	mm_stat_t     a_stat;
	mm_stat_t     b_stat;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		in_acc   = in_valid && in_ready;
		in_m     = modulus_value[W-1:0];
		in_one   = (in_m == W'(1)) ? '0 : W'(1);
		b_start  = (state_q == ST_LOOP) && (e_q != '0);
		a_start  = (in_acc && (in_m != '0)) || b_start;
		// reduction runs as (1 mod m) * base, exponent steps as r * b
		a_mcand  = (state_q == ST_IDLE) ? in_one : r_q;
		a_mplr   = (state_q == ST_IDLE) ? base_value[W-1:0] : b_q;
	end

	mexp_modmul #(.W(W)) u_mul_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (a_start),
		.mcand   (a_mcand),
		.mplr    (a_mplr),
		.modulus (m_q),
		.product (a_prod),
		.stat    (a_stat)
	);

	mexp_modmul #(.W(W)) u_mul_sq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (b_start),
		.mcand   (b_q),
		.mplr    (b_q),
		.modulus (m_q),
		.product (b_prod),
		.stat    (b_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			b_q         <= '0;
			e_q         <= '0;
			m_q         <= '0;
			r_q         <= '0;
			res_q       <= '0;
			err_q       <= 1'b0;
			pow_q       <= '0;
			oerr_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// in ST_FIN a free output register is reloaded below
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						m_q <= in_m;
						e_q <= exponent_value[W-1:0];
						r_q <= in_one;
						if (in_m == '0) begin
							res_q   <= '0;
							err_q   <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (a_stat.done) begin
						b_q     <= a_prod;
						state_q <= ST_LOOP;
					end
				end
				ST_LOOP: begin
					if (e_q == '0) begin
						res_q   <= r_q;
						err_q   <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (b_stat.done) begin
						if (e_q[0]) begin
							r_q <= a_prod;
						end
						b_q     <= b_prod;
						e_q     <= e_q >> 1;
						state_q <= ST_LOOP;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						pow_q       <= res_q;
						oerr_q      <= err_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign power_result       = FIELD_W'(pow_q);
	assign zero_modulus_error = oerr_q;

	// both multipliers start together, so they must finish together
	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (a_stat.done == b_stat.done))
		else $error("multipliers out of step");

	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!a_stat.busy && !b_stat.busy))
		else $error("new transaction taken while a multiplier is busy");

	a_r_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOP) |-> (r_q < m_q))
		else $error("running product not reduced");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && oerr_q) |-> (pow_q == '0))
		else $error("error result is not zero");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !out_ready) |=> $stable(pow_q))
		else $error("waiting result overwritten");

endmodule
